/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the quaternion-to-Euler block.
// Include this file by name; it defines nothing but the macros below.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/qre_pkg.sv */
// Package for the quaternion report to Euler angle unit: widths, constants,
// register indexes, the arctangent table and the structs between stages.
// No dependencies.
package qre_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int CORDIC_STEPS     = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;

  // Square root: 32 result bits, two per stage.
  localparam int ROOT_W       = 32;
  localparam int RAD_W        = 64;
  localparam int REM_W        = 36;
  localparam int ISQRT_STAGES = ROOT_W / 2;

  localparam int ARG_W  = 36;  // atan2 operands
  localparam int MAG_W  = 35;  // their magnitudes
  localparam int LEAD_W = 6;
  localparam int CX_W   = 34;  // CORDIC working registers
  localparam int Z_W    = 32;  // angle in centidegrees Q16

  localparam int CORDIC_LAT = 3 + CORDIC_STEPS + 2;
  localparam int SIDE_DLY   = 2 + ISQRT_STAGES;
  localparam int TOTAL_LAT  = 3 + SIDE_DLY + CORDIC_LAT;

  localparam logic [32:0]          NORM_SQ_MIN  = 33'd2684354;
  localparam logic [15:0]          MIN_LENGTH   = 16'd19;
  localparam logic [LEAD_W-1:0]    NORM_POS     = LEAD_W'(29);
  localparam logic signed [Z_W-1:0] QUARTER_TURN = 32'sd589824000;
  localparam logic signed [Z_W-1:0] HALF_TURN    = 32'sd1179648000;
  localparam logic [16:0]          CDEG_LIMIT   = 17'd18000;

  localparam int            CFG_IDX_W   = 2;
  localparam logic [7:0]    TS_ID_RESET  = 8'd251;
  localparam logic [7:0]    ROT_ID_RESET = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TS_ID  = 2'd0,
    CFG_ROT_ID = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ARG_W-1:0] rn;
    logic signed [ARG_W-1:0] rd;
    logic signed [ARG_W-1:0] yn;
    logic signed [ARG_W-1:0] yd;
    logic signed [ARG_W-1:0] pit_y;
    logic                    ok;
    logic [1:0]              acc;
  } side_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] acc;
  } meta_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } flags_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // atan(2^-i) in centidegrees Q16.
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:  v = 32'sd294912000;
      5'd1:  v = 32'sd174096719;
      5'd2:  v = 32'sd91987925;
      5'd3:  v = 32'sd46694507;
      5'd4:  v = 32'sd23437865;
      5'd5:  v = 32'sd11730358;
      5'd6:  v = 32'sd5866610;
      5'd7:  v = 32'sd2933484;
      5'd8:  v = 32'sd1466764;
      5'd9:  v = 32'sd733385;
      5'd10: v = 32'sd366693;
      5'd11: v = 32'sd183346;
      5'd12: v = 32'sd91673;
      5'd13: v = 32'sd45837;
      5'd14: v = 32'sd22918;
      5'd15: v = 32'sd11459;
      5'd16: v = 32'sd5730;
      5'd17: v = 32'sd2865;
      5'd18: v = 32'sd1432;
      5'd19: v = 32'sd716;
      5'd20: v = 32'sd358;
      5'd21: v = 32'sd179;
      5'd22: v = 32'sd90;
      5'd23: v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/qre_if.sv */
// Handshake channels of the quaternion report to Euler angle unit:
// the report input beat and the angle result beat. No dependencies.
interface qre_rpt_if;
  logic               valid;
  logic               ready;
  logic [15:0]        payload_length;
  logic [7:0]         header_id;
  logic [7:0]         report_code;
  logic [7:0]         status_byte;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, payload_length, header_id, report_code, status_byte,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, payload_length, header_id, report_code, status_byte,
                  quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qre_ang_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_ang;
  logic signed [15:0] pitch_ang;
  logic signed [15:0] yaw_ang;
  logic [1:0]         accuracy;
  logic               ok;

  modport source (output valid, roll_ang, pitch_ang, yaw_ang, accuracy, ok,
                  input ready);
  modport sink   (input valid, roll_ang, pitch_ang, yaw_ang, accuracy, ok,
                  output ready);
endinterface

/* rtl/quaternion_report_to_euler_unit.sv */
// Top level of the quaternion report to Euler angle unit: report checks,
// quaternion products, pitch root and three CORDIC angle pipelines.
// Depends on qre_pkg, qre_if, qre_isqrt, qre_cordic and assert_macros.svh.
//
//   channel  | dir | handshake       | beat
//   rpt_i    | in  | valid / ready   | one parsed rotation-vector report
//   ang_o    | out | valid / ready   | roll, pitch, yaw, accuracy, ok
//   cfg      | in  | cfg_we_i only   | report ID registers, no read-back
//
// One report enters per cycle unless the output beat is held. Each result
// passes 3 product and check stages, 2 root-operand stages, 16 square-root
// stages, then the CORDIC pipeline of 5 + steps.
// Reset clears the valid bits and restores the report ID registers.
// When the output beat is held, every stage holds; nothing is dropped.
`include "assert_macros.svh"
module quaternion_report_to_euler_unit import qre_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  qre_rpt_if.sink              rpt_i,
  qre_ang_if.source            ang_o
);

  logic [7:0] ts_id_q, rot_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_id_q  <= TS_ID_RESET;
      rot_id_q <= ROT_ID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TS_ID:  ts_id_q  <= cfg_wdata_i;
        CFG_ROT_ID: rot_id_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic                 en;
  logic [TOTAL_LAT-1:0] vld_q;

  assign en          = !vld_q[TOTAL_LAT-1] || ang_o.ready;
  assign rpt_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[TOTAL_LAT-2:0], rpt_i.valid};
  end

  // Stage 1: component products and header checks.
  logic signed [31:0] p_xx_q, p_yy_q, p_zz_q, p_ww_q;
  logic signed [31:0] p_wx_q, p_yz_q, p_wz_q, p_xy_q, p_wy_q, p_zx_q;
  logic               pass1_q;
  logic [1:0]         acc1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_xx_q  <= rpt_i.quat_x * rpt_i.quat_x;
      p_yy_q  <= rpt_i.quat_y * rpt_i.quat_y;
      p_zz_q  <= rpt_i.quat_z * rpt_i.quat_z;
      p_ww_q  <= rpt_i.quat_w * rpt_i.quat_w;
      p_wx_q  <= rpt_i.quat_w * rpt_i.quat_x;
      p_yz_q  <= rpt_i.quat_y * rpt_i.quat_z;
      p_wz_q  <= rpt_i.quat_w * rpt_i.quat_z;
      p_xy_q  <= rpt_i.quat_x * rpt_i.quat_y;
      p_wy_q  <= rpt_i.quat_w * rpt_i.quat_y;
      p_zx_q  <= rpt_i.quat_z * rpt_i.quat_x;
      pass1_q <= (rpt_i.payload_length >= MIN_LENGTH) && (rpt_i.header_id == ts_id_q) &&
                 (rpt_i.report_code == rot_id_q);
      acc1_q  <= rpt_i.status_byte[1:0];
    end
  end

  // Stage 2: squared norm and the atan2 operands.
  logic [32:0]             s2_d, s2_q;
  logic signed [ARG_W-1:0] rn2_d, rd2_d, yn2_d, yd2_d, a2_d;
  logic signed [ARG_W-1:0] rn2_q, rd2_q, yn2_q, yd2_q, a2_q;
  logic                    ok2_q;
  logic [1:0]              acc2_q;

  always_comb begin
    s2_d  = {2'b0, p_xx_q[30:0]} + {2'b0, p_yy_q[30:0]} +
            {2'b0, p_zz_q[30:0]} + {2'b0, p_ww_q[30:0]};
    rn2_d = (ARG_W'(p_wx_q) + ARG_W'(p_yz_q)) <<< 1;
    yn2_d = (ARG_W'(p_wz_q) + ARG_W'(p_xy_q)) <<< 1;
    a2_d  = (ARG_W'(p_wy_q) - ARG_W'(p_zx_q)) <<< 1;
    rd2_d = $signed({3'b0, s2_d}) - ((ARG_W'(p_xx_q) + ARG_W'(p_yy_q)) <<< 1);
    yd2_d = $signed({3'b0, s2_d}) - ((ARG_W'(p_yy_q) + ARG_W'(p_zz_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q   <= s2_d;
      rn2_q  <= rn2_d;
      rd2_q  <= rd2_d;
      yn2_q  <= yn2_d;
      yd2_q  <= yd2_d;
      a2_q   <= a2_d;
      ok2_q  <= pass1_q && (s2_d > NORM_SQ_MIN);
      acc2_q <= acc1_q;
    end
  end

  // Stage 3: clamp the asin argument to the norm and halve both when large.
  logic [MAG_W-1:0] amag;
  logic [32:0]      ua_c;
  logic [31:0]      us3_d, ua3_d, us3_q, ua3_q;
  side_t            side3_d, side3_q;

  always_comb begin
    amag = a2_q[ARG_W-1] ? MAG_W'(-a2_q) : MAG_W'(a2_q);
    ua_c = (amag > {2'b0, s2_q}) ? s2_q : amag[32:0];
    if (s2_q > 33'h0_8000_0000) begin
      us3_d = s2_q[32:1];
      ua3_d = ua_c[32:1];
    end else begin
      us3_d = s2_q[31:0];
      ua3_d = ua_c[31:0];
    end
    side3_d.rn    = rn2_q;
    side3_d.rd    = rd2_q;
    side3_d.yn    = yn2_q;
    side3_d.yd    = yd2_q;
    side3_d.pit_y = a2_q[ARG_W-1] ? -$signed({4'b0, ua3_d}) : $signed({4'b0, ua3_d});
    side3_d.ok    = ok2_q;
    side3_d.acc   = acc2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      us3_q   <= us3_d;
      ua3_q   <= ua3_d;
      side3_q <= side3_d;
    end
  end

  // Stages 4 and 5: radicand of the pitch cosine.
  logic [RAD_W-1:0] usq_q, uasq_q, diff_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      usq_q  <= us3_q * us3_q;
      uasq_q <= ua3_q * ua3_q;
      diff_q <= usq_q - uasq_q;
    end
  end

  logic [ROOT_W-1:0] root;

  qre_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (diff_q),
    .root_o (root)
  );

  side_t side_q [SIDE_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side3_q;
      for (int k = 1; k < SIDE_DLY; k++) side_q[k] <= side_q[k-1];
    end
  end

  side_t              sd;
  logic signed [15:0] roll_res, pitch_res, yaw_res;

  assign sd = side_q[SIDE_DLY-1];

  qre_cordic u_roll (
    .clk_i  (clk_i),
    .en_i   (en),
    .y_i    (sd.rn),
    .x_i    (sd.rd),
    .cdeg_o (roll_res)
  );

  qre_cordic u_pitch (
    .clk_i  (clk_i),
    .en_i   (en),
    .y_i    (sd.pit_y),
    .x_i    ($signed({{(ARG_W-ROOT_W){1'b0}}, root})),
    .cdeg_o (pitch_res)
  );

  qre_cordic u_yaw (
    .clk_i  (clk_i),
    .en_i   (en),
    .y_i    (sd.yn),
    .x_i    (sd.yd),
    .cdeg_o (yaw_res)
  );

  meta_t meta_q [CORDIC_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= '{ok: sd.ok, acc: sd.acc};
      for (int k = 1; k < CORDIC_LAT; k++) meta_q[k] <= meta_q[k-1];
    end
  end

  meta_t mo;
  assign mo = meta_q[CORDIC_LAT-1];

  assign ang_o.valid     = vld_q[TOTAL_LAT-1];
  assign ang_o.ok        = mo.ok;
  assign ang_o.accuracy  = mo.ok ? mo.acc : 2'b00;
  assign ang_o.roll_ang  = mo.ok ? roll_res : 16'sd0;
  assign ang_o.pitch_ang = mo.ok ? pitch_res : 16'sd0;
  assign ang_o.yaw_ang   = mo.ok ? yaw_res : 16'sd0;

  // An accepted beat always shows up in the first stage.
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, rpt_i.valid && rpt_i.ready, vld_q[0], "accepted beat lost at pipeline entry")
  // A held output freezes every valid bit in the pipeline.
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !en, $stable(vld_q), "pipeline moved during a stall")
  // Accepted pitch stays within a quarter turn.
  `ASSERT_SAME(a_pitch_range, clk_i, rst_ni, ang_o.valid && ang_o.ok, (ang_o.pitch_ang <= 16'sd9000) && (ang_o.pitch_ang >= -16'sd9000), "pitch outside a quarter turn")

endmodule

/* rtl/qre_isqrt.sv */
// Pipelined floor integer square root, two result bits per stage.
// Depends on qre_pkg.
module qre_isqrt import qre_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  function automatic sq_t sq_step(input sq_t s);
    sq_t              r;
    logic [REM_W-1:0] trial;
    r.rem  = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
    r.rad  = {s.rad[RAD_W-3:0], 2'b00};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    if (r.rem >= trial) begin
      r.rem  = r.rem - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  sq_t src0;
  sq_t st_q [ISQRT_STAGES];

  assign src0 = '{rad: rad_i, rem: '0, root: '0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sq_step(sq_step(src0));
      for (int k = 1; k < ISQRT_STAGES; k++) st_q[k] <= sq_step(sq_step(st_q[k-1]));
    end
  end

  assign root_o = st_q[ISQRT_STAGES-1].root;

endmodule

/* rtl/qre_cordic.sv */
// Pipelined atan2 in centidegrees: magnitude, normalization, vectoring
// CORDIC steps, quadrant fix-up and rounding. Depends on qre_pkg.
module qre_cordic import qre_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ARG_W-1:0] y_i,
  input  logic signed [ARG_W-1:0] x_i,
  output logic signed [15:0]      cdeg_o
);

  // Magnitudes and signs.
  logic [MAG_W-1:0] ya_q, xa_q;
  flags_t           fa_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ya_q    <= y_i[ARG_W-1] ? MAG_W'(-y_i) : MAG_W'(y_i);
      xa_q    <= x_i[ARG_W-1] ? MAG_W'(-x_i) : MAG_W'(x_i);
      fa_q    <= '{xneg: x_i[ARG_W-1], yneg: y_i[ARG_W-1],
                   zero: (y_i == '0) && (x_i == '0)};
    end
  end

  // Leading one of the larger magnitude.
  logic [MAG_W-1:0]  mx;
  logic [LEAD_W-1:0] lead_d, lead_q;
  logic [MAG_W-1:0]  yb_q, xb_q;
  flags_t            fb_q;

  always_comb begin
    mx     = (ya_q > xa_q) ? ya_q : xa_q;
    lead_d = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx[b]) lead_d = LEAD_W'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lead_q <= lead_d;
      yb_q   <= ya_q;
      xb_q   <= xa_q;
      fb_q   <= fa_q;
    end
  end

  // Shift so that the larger magnitude lies in [2^29, 2^30).
  logic [MAG_W-1:0] ys, xs;

  always_comb begin
    if (lead_q > NORM_POS) begin
      ys = yb_q >> (lead_q - NORM_POS);
      xs = xb_q >> (lead_q - NORM_POS);
    end else begin
      ys = yb_q << (NORM_POS - lead_q);
      xs = xb_q << (NORM_POS - lead_q);
    end
  end

  logic signed [CX_W-1:0] cx_q [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cy_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_q  [CORDIC_STEPS+1];
  flags_t                 fl_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= $signed({{(CX_W-30){1'b0}}, xs[29:0]});
      cy_q[0] <= $signed({{(CX_W-30){1'b0}}, ys[29:0]});
      z_q[0]  <= '0;
      fl_q[0] <= fb_q;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        if (cy_q[k] > 0) begin
          cx_q[k+1] <= cx_q[k] + (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] - (cx_q[k] >>> k);
          z_q[k+1]  <= z_q[k] + atan_q16(5'(k));
        end else begin
          cx_q[k+1] <= cx_q[k] - (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] + (cx_q[k] >>> k);
          z_q[k+1]  <= z_q[k] - atan_q16(5'(k));
        end
        fl_q[k+1] <= fl_q[k];
      end
    end
  end

  // Clamp to the first quadrant, then mirror and negate by the operand signs.
  logic signed [Z_W-1:0] zc, ang_d, ang_q;
  flags_t                ff;

  always_comb begin
    ff = fl_q[CORDIC_STEPS];
    zc = z_q[CORDIC_STEPS];
    if (zc < 0) zc = '0;
    if (zc > QUARTER_TURN) zc = QUARTER_TURN;
    if (ff.xneg) zc = HALF_TURN - zc;
    if (ff.yneg) zc = -zc;
    ang_d = ff.zero ? '0 : zc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) ang_q <= ang_d;
  end

  // Round half away from zero to whole centidegrees and saturate.
  logic [Z_W-1:0]     mag;
  logic [Z_W:0]       rsum;
  logic [16:0]        r17;
  logic [14:0]        r15;
  logic signed [15:0] cdeg_d;

  always_comb begin
    mag    = ang_q[Z_W-1] ? Z_W'(-ang_q) : Z_W'(ang_q);
    rsum   = {1'b0, mag} + 33'd32768;
    r17    = rsum[Z_W:16];
    r15    = (r17 > CDEG_LIMIT) ? CDEG_LIMIT[14:0] : r17[14:0];
    cdeg_d = ang_q[Z_W-1] ? -$signed({1'b0, r15}) : $signed({1'b0, r15});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cdeg_o <= cdeg_d;
  end

endmodule
